>>> rtl/q2e_pkg.sv
// ============================================================================
// q2e_pkg: shared types, constants and helpers
// Widths, status codes, the CORDIC arctangent table and the stage payloads
// used by the quaternion to Euler angle pipeline.
// ============================================================================
package q2e_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int TABLE_LEN         = 24;

    // Quotient and square root widths (both results are at most 2^30).
    localparam int Q_BITS = 31;
    localparam int S_BITS = 31;

    // CORDIC lane vector width and internal angle width (2^-22 degree).
    localparam int LW = 38;
    localparam int AW = 32;

    localparam logic signed [AW-1:0] HALF_TURN = 32'sd754974720;

    localparam logic signed [13:0] QUARTER_OUT = 14'sd5760;
    localparam logic signed [17:0] LIM_X = 18'sd11520;
    localparam logic signed [17:0] LIM_Y = 18'sd23040;
    localparam logic signed [17:0] LIM_Z = 18'sd5760;

    localparam logic [1:0] ST_NORMAL = 2'd0;
    localparam logic [1:0] ST_NORTH  = 2'd1;
    localparam logic [1:0] ST_SOUTH  = 2'd2;
    localparam logic [1:0] ST_ZERO   = 2'd3;

    // Fields carried alongside the divider and square root chains.
    typedef struct packed {
        logic [1:0]          status;
        logic                tneg;
        logic signed [33:0]  ny;
        logic signed [33:0]  dy;
        logic signed [33:0]  nx;
        logic signed [33:0]  dx;
        logic signed [15:0]  qx;
        logic signed [15:0]  qw;
    } side_t;

    typedef struct packed {
        logic [33:0]       rem;
        logic [32:0]       unit;
        logic [Q_BITS-1:0] quo;
        side_t             side;
    } div_t;

    typedef struct packed {
        logic [60:0]       rem;
        logic [S_BITS-1:0] res;
        logic [Q_BITS-1:0] r;
        side_t             side;
    } sq_t;

    typedef struct packed {
        logic signed [LW-1:0] xv;
        logic signed [LW-1:0] yv;
        logic signed [AW-1:0] ang;
    } lane_t;

    typedef struct packed {
        lane_t      ly;
        lane_t      lz;
        lane_t      lx;
        logic [1:0] status;
    } cord_t;

    // atan(2^-i) in units of 2^-22 degree, rounded to nearest.
    function automatic logic [AW-1:0] atan_entry(input int i);
        logic [AW-1:0] v;
        case (i)
            0:       v = 32'd188743680;
            1:       v = 32'd111421900;
            2:       v = 32'd58872272;
            3:       v = 32'd29884485;
            4:       v = 32'd15000234;
            5:       v = 32'd7507429;
            6:       v = 32'd3754631;
            7:       v = 32'd1877430;
            8:       v = 32'd938729;
            9:       v = 32'd469366;
            10:      v = 32'd234683;
            11:      v = 32'd117342;
            12:      v = 32'd58671;
            13:      v = 32'd29335;
            14:      v = 32'd14668;
            15:      v = 32'd7334;
            16:      v = 32'd3667;
            17:      v = 32'd1833;
            18:      v = 32'd917;
            19:      v = 32'd458;
            20:      v = 32'd229;
            21:      v = 32'd115;
            22:      v = 32'd57;
            23:      v = 32'd29;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Fold a vector into the right half plane, presetting +-180 degrees.
    function automatic lane_t preset(input logic signed [LW-1:0] yv,
                                     input logic signed [LW-1:0] xv);
        lane_t l;
        if (xv[LW-1]) begin
            l.ang = yv[LW-1] ? -HALF_TURN : HALF_TURN;
            l.xv  = -xv;
            l.yv  = -yv;
        end else begin
            l.ang = '0;
            l.xv  = xv;
            l.yv  = yv;
        end
        return l;
    endfunction

    // Round an internal angle to the nearest 1/64 degree (floor of a + half).
    function automatic logic signed [17:0] to_out(input logic signed [33:0] a);
        logic signed [33:0] s;
        s = a + 34'sd32768;
        return s[33:16];
    endfunction

    function automatic logic signed [17:0] clamp(input logic signed [17:0] v,
                                                 input logic signed [17:0] lim);
        logic signed [17:0] o;
        if (v > lim) begin
            o = lim;
        end else if (v < -lim) begin
            o = -lim;
        end else begin
            o = v;
        end
        return o;
    endfunction

endpackage

>>> rtl/q2e_div_cell.sv
// ============================================================================
// q2e_div_cell: one restoring division step
// Produces one quotient bit of |2*test| * 2^30 / unit per cell.
// ============================================================================
module q2e_div_cell
    import q2e_pkg::*;
#(
    parameter bit FIRST = 1'b0
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic ce,
    input  logic in_valid,
    input  div_t in_data,
    output logic out_valid,
    output div_t out_data
);

    logic  valid_reg;
    div_t  data_reg;
    div_t  data_next;
    logic [33:0] rem_d;
    logic        ge;

    always_comb begin
        // The first step starts from the dividend itself, which never exceeds unit.
        rem_d     = FIRST ? in_data.rem : {in_data.rem[32:0], 1'b0};
        ge        = rem_d >= {1'b0, in_data.unit};
        data_next = in_data;
        data_next.rem = ge ? rem_d - {1'b0, in_data.unit} : rem_d;
        data_next.quo = {in_data.quo[Q_BITS-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
        if (ce) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/q2e_sqrt_cell.sv
// ============================================================================
// q2e_sqrt_cell: one integer square root step
// Decides one result bit by comparing the remainder against the trial term.
// ============================================================================
module q2e_sqrt_cell
    import q2e_pkg::*;
#(
    parameter int BITPOS = 0
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic ce,
    input  logic in_valid,
    input  sq_t  in_data,
    output logic out_valid,
    output sq_t  out_data
);

    logic  valid_reg;
    sq_t   data_reg;
    sq_t   data_next;
    logic [61:0] trial;
    logic        ge;

    always_comb begin
        // (res + 2^b)^2 - res^2 = res * 2^(b+1) + 2^(2b)
        trial = ({31'd0, in_data.res} << (BITPOS + 1)) + (62'd1 << (2 * BITPOS));
        ge    = {1'b0, in_data.rem} >= trial;
        data_next = in_data;
        if (ge) begin
            data_next.rem = in_data.rem - trial[60:0];
            data_next.res = in_data.res | (S_BITS'(1) << BITPOS);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
        if (ce) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/q2e_cordic_cell.sv
// ============================================================================
// q2e_cordic_cell: one vectoring CORDIC rotation for three lanes
// Rotates each lane toward the x axis and accumulates the angle.
// ============================================================================
module q2e_cordic_cell
    import q2e_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  ce,
    input  logic  in_valid,
    input  cord_t in_data,
    output logic  out_valid,
    output cord_t out_data
);

    localparam logic signed [AW-1:0] ATAN = $signed(atan_entry(STAGE));

    logic  valid_reg;
    cord_t data_reg;
    cord_t data_next;

    function automatic lane_t rotate(input lane_t l);
        lane_t o;
        logic signed [LW-1:0] xs;
        logic signed [LW-1:0] ys;
        xs = l.xv >>> STAGE;
        ys = l.yv >>> STAGE;
        if (!l.yv[LW-1]) begin
            o.xv  = l.xv + ys;
            o.yv  = l.yv - xs;
            o.ang = l.ang + ATAN;
        end else begin
            o.xv  = l.xv - ys;
            o.yv  = l.yv + xs;
            o.ang = l.ang - ATAN;
        end
        return o;
    endfunction

    always_comb begin
        data_next.ly     = rotate(in_data.ly);
        data_next.lz     = rotate(in_data.lz);
        data_next.lx     = rotate(in_data.lx);
        data_next.status = in_data.status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
        if (ce) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/quaternion_to_euler_top.sv
// ============================================================================
// quaternion_to_euler_top: quaternion to Euler angles with pole handling
// Products, sums, a divider chain, a square root chain and CORDIC cells.
// ============================================================================
// One quaternion beat is taken every clock cycle unless the pipeline holds,
// and each gives exactly one result beat, in order. The stages, in order:
// two product and sum stages, a 31-cell restoring divider for 2*test/unit,
// the square term, a 31-cell square root chain, a quadrant fold, the CORDIC
// cells (three lanes side by side) and the output register. The whole
// pipeline advances together; it holds only when a result waits at the
// output and the last cell is full.
module quaternion_to_euler_top
    import q2e_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // qx[15:0], qy[31:16], qz[47:32], qw[63:48]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // angle_x[14:0], angle_y[30:15], angle_z[44:31], zeros
    output logic [1:0]  m_tuser    // pole_status[1:0]
);

    logic ce;
    logic out_load;
    logic last_valid;

    // ---------------- products ----------------
    logic               p_valid_reg;
    logic signed [31:0] sqx_reg, sqy_reg, sqz_reg, sqw_reg;
    logic signed [31:0] pxy_reg, pzw_reg, pyw_reg, pxz_reg, pxw_reg, pyz_reg;
    logic signed [15:0] p_qx_reg, p_qw_reg;
    logic signed [15:0] in_x, in_y, in_z, in_w;

    assign in_x = $signed(s_tdata[15:0]);
    assign in_y = $signed(s_tdata[31:16]);
    assign in_z = $signed(s_tdata[47:32]);
    assign in_w = $signed(s_tdata[63:48]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (ce) begin
            p_valid_reg <= s_tvalid;
        end
        if (ce) begin
            sqx_reg  <= in_x * in_x;
            sqy_reg  <= in_y * in_y;
            sqz_reg  <= in_z * in_z;
            sqw_reg  <= in_w * in_w;
            pxy_reg  <= in_x * in_y;
            pzw_reg  <= in_z * in_w;
            pyw_reg  <= in_y * in_w;
            pxz_reg  <= in_x * in_z;
            pxw_reg  <= in_x * in_w;
            pyz_reg  <= in_y * in_z;
            p_qx_reg <= in_x;
            p_qw_reg <= in_w;
        end
    end

    // ---------------- sums ----------------
    logic               a_valid_reg;
    logic [32:0]        unit_reg;
    logic signed [32:0] test_reg;
    logic signed [33:0] ny_reg, dy_reg, nx_reg, dx_reg;
    logic signed [15:0] a_qx_reg, a_qw_reg;
    logic signed [33:0] unit_sum;
    logic signed [33:0] dyw, dxw;

    always_comb begin
        unit_sum = 34'(sqx_reg) + 34'(sqy_reg) + 34'(sqz_reg) + 34'(sqw_reg);
        dyw      = 34'(pyw_reg) - 34'(pxz_reg);
        dxw      = 34'(pxw_reg) - 34'(pyz_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (ce) begin
            a_valid_reg <= p_valid_reg;
        end
        if (ce) begin
            unit_reg <= unit_sum[32:0];
            test_reg <= 33'(pxy_reg) + 33'(pzw_reg);
            ny_reg   <= dyw <<< 1;
            nx_reg   <= dxw <<< 1;
            dy_reg   <= 34'(sqx_reg) - 34'(sqy_reg) - 34'(sqz_reg) + 34'(sqw_reg);
            dx_reg   <= -34'(sqx_reg) + 34'(sqy_reg) - 34'(sqz_reg) + 34'(sqw_reg);
            a_qx_reg <= p_qx_reg;
            a_qw_reg <= p_qw_reg;
        end
    end

    // ---------------- branch decision and divider entry ----------------
    logic signed [43:0] test_k, unit_k;
    logic signed [33:0] t2;
    logic [33:0]        t2_abs;
    logic [1:0]         status_c;
    div_t               div_in;

    always_comb begin
        test_k = 44'(test_reg) * 44'sd1000;
        unit_k = $signed({11'd0, unit_reg}) * 44'sd499;
        if (unit_reg == '0) begin
            status_c = ST_ZERO;
        end else if (test_k > unit_k) begin
            status_c = ST_NORTH;
        end else if (test_k < -unit_k) begin
            status_c = ST_SOUTH;
        end else begin
            status_c = ST_NORMAL;
        end
        t2     = 34'(test_reg) <<< 1;
        t2_abs = t2[33] ? 34'(-t2) : 34'(t2);
        div_in.rem         = {1'b0, t2_abs[32:0]};
        div_in.unit        = unit_reg;
        div_in.quo         = '0;
        div_in.side.status = status_c;
        div_in.side.tneg   = t2[33];
        div_in.side.ny     = ny_reg;
        div_in.side.dy     = dy_reg;
        div_in.side.nx     = nx_reg;
        div_in.side.dx     = dx_reg;
        div_in.side.qx     = a_qx_reg;
        div_in.side.qw     = a_qw_reg;
    end

    // ---------------- divider chain ----------------
    div_t div_bus   [0:Q_BITS];
    logic div_valid [0:Q_BITS];

    assign div_bus[0]   = div_in;
    assign div_valid[0] = a_valid_reg;

    genvar gi;
    generate
        for (gi = 0; gi < Q_BITS; gi++) begin : g_div
            q2e_div_cell #(
                .FIRST (gi == 0)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ce        (ce),
                .in_valid  (div_valid[gi]),
                .in_data   (div_bus[gi]),
                .out_valid (div_valid[gi+1]),
                .out_data  (div_bus[gi+1])
            );
        end
    endgenerate

    // ---------------- square term ----------------
    logic              r_valid_reg;
    sq_t               sq_start_reg;
    logic [Q_BITS-1:0] r_cap;
    logic [61:0]       r_sq;

    always_comb begin
        if (div_bus[Q_BITS].quo > (Q_BITS'(1) << 30)) begin
            r_cap = Q_BITS'(1) << 30;
        end else begin
            r_cap = div_bus[Q_BITS].quo;
        end
        r_sq = {31'd0, r_cap} * {31'd0, r_cap};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg <= 1'b0;
        end else if (ce) begin
            r_valid_reg <= div_valid[Q_BITS];
        end
        if (ce) begin
            sq_start_reg.rem  <= (61'd1 << 60) - r_sq[60:0];
            sq_start_reg.res  <= '0;
            sq_start_reg.r    <= r_cap;
            sq_start_reg.side <= div_bus[Q_BITS].side;
        end
    end

    // ---------------- square root chain ----------------
    sq_t  sq_bus   [0:S_BITS];
    logic sq_valid [0:S_BITS];

    assign sq_bus[0]   = sq_start_reg;
    assign sq_valid[0] = r_valid_reg;

    generate
        for (gi = 0; gi < S_BITS; gi++) begin : g_sqrt
            q2e_sqrt_cell #(
                .BITPOS (S_BITS - 1 - gi)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ce        (ce),
                .in_valid  (sq_valid[gi]),
                .in_data   (sq_bus[gi]),
                .out_valid (sq_valid[gi+1]),
                .out_data  (sq_bus[gi+1])
            );
        end
    endgenerate

    // ---------------- lane setup and quadrant fold ----------------
    logic                 pre_valid_reg;
    cord_t                pre_reg;
    side_t                sd;
    logic signed [LW-1:0] ly_y, ly_x, lz_y, lz_x;
    logic                 pole;

    always_comb begin
        sd   = sq_bus[S_BITS].side;
        pole = (sd.status == ST_NORTH) || (sd.status == ST_SOUTH);
        // At the poles the heading lane works on atan2(qx, qw) instead.
        ly_y = pole ? LW'(sd.qx) : LW'(sd.ny);
        ly_x = pole ? LW'(sd.qw) : LW'(sd.dy);
        lz_y = sd.tneg ? -LW'($signed({1'b0, sq_bus[S_BITS].r}))
                       :  LW'($signed({1'b0, sq_bus[S_BITS].r}));
        lz_x = LW'($signed({1'b0, sq_bus[S_BITS].res}));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_valid_reg <= 1'b0;
        end else if (ce) begin
            pre_valid_reg <= sq_valid[S_BITS];
        end
        if (ce) begin
            pre_reg.ly     <= preset(ly_y, ly_x);
            pre_reg.lz     <= preset(lz_y, lz_x);
            pre_reg.lx     <= preset(LW'(sd.nx), LW'(sd.dx));
            pre_reg.status <= sd.status;
        end
    end

    // ---------------- CORDIC cells ----------------
    cord_t cd_bus   [0:CORDIC_STAGES];
    logic  cd_valid [0:CORDIC_STAGES];

    assign cd_bus[0]   = pre_reg;
    assign cd_valid[0] = pre_valid_reg;

    generate
        for (gi = 0; gi < CORDIC_STAGES; gi++) begin : g_cordic
            q2e_cordic_cell #(
                .STAGE (gi)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ce        (ce),
                .in_valid  (cd_valid[gi]),
                .in_data   (cd_bus[gi]),
                .out_valid (cd_valid[gi+1]),
                .out_data  (cd_bus[gi+1])
            );
        end
    endgenerate

    assign last_valid = cd_valid[CORDIC_STAGES];

    // ---------------- output register ----------------
    logic               m_tvalid_reg;
    logic signed [14:0] angle_x_reg;
    logic signed [15:0] angle_y_reg;
    logic signed [13:0] angle_z_reg;
    logic [1:0]         status_reg;
    logic signed [14:0] angle_x_next;
    logic signed [15:0] angle_y_next;
    logic signed [13:0] angle_z_next;
    logic signed [33:0] ay_dbl;
    logic signed [17:0] rx, ry, rz;
    cord_t              fin;

    always_comb begin
        fin    = cd_bus[CORDIC_STAGES];
        ay_dbl = {fin.ly.ang[AW-1], fin.ly.ang, 1'b0};
        rx = clamp(to_out(34'(fin.lx.ang)), LIM_X);
        rz = clamp(to_out(34'(fin.lz.ang)), LIM_Z);
        unique case (fin.status)
            ST_NORTH: begin
                ry = clamp(to_out(ay_dbl), LIM_Y);
                angle_x_next = '0;
                angle_z_next = QUARTER_OUT;
            end
            ST_SOUTH: begin
                ry = clamp(to_out(-ay_dbl), LIM_Y);
                angle_x_next = '0;
                angle_z_next = -QUARTER_OUT;
            end
            ST_ZERO: begin
                ry = '0;
                angle_x_next = '0;
                angle_z_next = '0;
            end
            default: begin
                ry = clamp(to_out(34'(fin.ly.ang)), LIM_Y);
                angle_x_next = rx[14:0];
                angle_z_next = rz[13:0];
            end
        endcase
        angle_y_next = ry[15:0];
    end

    assign out_load = !m_tvalid_reg || m_tready;
    // The pipeline may also advance under a stalled output when the last cell is empty.
    assign ce       = out_load || !last_valid;
    assign s_tready = ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= last_valid;
        end
        if (out_load) begin
            angle_x_reg <= angle_x_next;
            angle_y_reg <= angle_y_next;
            angle_z_reg <= angle_z_next;
            status_reg  <= fin.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'd0, angle_z_reg, angle_y_reg, angle_x_reg};
    assign m_tuser  = status_reg;

    // ---------------- assertions ----------------
    a_north: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && status_reg == ST_NORTH) |-> (angle_z_reg == QUARTER_OUT && angle_x_reg == '0))
        else $error("north pole beat has wrong fixed angles");

    a_south: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && status_reg == ST_SOUTH) |-> (angle_z_reg == -QUARTER_OUT && angle_x_reg == '0))
        else $error("south pole beat has wrong fixed angles");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && status_reg == ST_ZERO)
            |-> (angle_x_reg == '0 && angle_y_reg == '0 && angle_z_reg == '0))
        else $error("zero quaternion beat has nonzero angles");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && last_valid) |-> !s_tready)
        else $error("input taken while the full pipeline is stalled");

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> p_valid_reg)
        else $error("accepted beat did not enter the product stage");

endmodule
